>>> rtl/spg_pkg.sv
// ============================================================================
// spg_pkg - step/direction pulse generator shared definitions
// Types, widths and constants used by the front queue, back sequencer,
// divider and top level.
// ============================================================================
`default_nettype none

package spg_pkg;

    localparam int POS_W       = 48;
    localparam int HALF_W      = 20;
    localparam int SPEED_W     = 17;
    localparam int REV_W       = 24;
    localparam int POWER_W     = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_W       = 48;
    localparam int DVSR_W      = 25;
    localparam int MUL_A_W     = 33;
    localparam int MUL_B_W     = 16;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int QUEUE_DEPTH = 2;

    // frequency rounding divide: 960 = 64 * 15, 31457280 = 2^21 * 15
    localparam int SCALE_W   = 27;
    localparam int RECIP_W   = 28;
    localparam int RECIP_SH  = 31;
    localparam int RPM_SHIFT = 6;
    localparam int PWR_SHIFT = 21;
    // ceil(2^31 / 15), exact for every scaled value below 2^27
    localparam logic [RECIP_W-1:0] RECIP_15 = 28'h888_8889;

    localparam int TICKS_DEFAULT = 500000;

    localparam logic [HALF_W-1:0] HALF_MAX  = {HALF_W{1'b1}};
    localparam logic [DIV_W-1:0]  RPM_ROUND = DIV_W'(480);
    localparam logic [DIV_W-1:0]  PWR_ROUND = DIV_W'(15728640);
    localparam logic [MUL_B_W-1:0] NEAR_SCALE = MUL_B_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PRESENT = 2'd2;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_RUN_RPM,
        CMD_RUN_POWER,
        CMD_MOVE_BY,
        CMD_MOVE_TO,
        CMD_STOP,
        CMD_SET_ZERO,
        CMD_NONE
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_OK,
        ERR_SLOW_MOVE,
        ERR_NO_LIMIT
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RPM_MUL,
        ST_PWR_MUL1,
        ST_PWR_MUL2,
        ST_DIST_MUL,
        ST_BY_SET,
        ST_ZERO_SET,
        ST_TO_EVAL,
        ST_TO_MUL,
        ST_TO_DEC,
        ST_FREQ_SCALE,
        ST_FREQ_MUL,
        ST_DIVH_GO,
        ST_DIVH_WAIT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_cmd                      cmd;
        logic signed [SPEED_W-1:0] speed;
        logic signed [REV_W-1:0]   revs;
        logic signed [POWER_W-1:0] power;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] steps_per_rev;
        logic [CFG_W-1:0] max_speed;
        logic             enable_present;
    } t_cfg;

    typedef struct packed {
        logic                    step_level;
        logic                    dir_level;
        logic                    enable_n;
        logic signed [POS_W-1:0] position;
        logic                    moving;
        logic                    move_done;
        t_err                    err;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/spg_front.sv
// ============================================================================
// spg_front - command intake
// Decodes the command code and holds beats in a short queue so the back
// sequencer and the input side stall independently.
// ============================================================================
`default_nettype none

module spg_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [2:0]                       i_command,
    input  wire  signed [spg_pkg::SPEED_W-1:0] i_speed_q4,
    input  wire  signed [spg_pkg::REV_W-1:0]   i_revolutions_q8,
    input  wire  signed [spg_pkg::POWER_W-1:0] i_power_q15,
    output logic                             o_head_valid,
    output spg_pkg::t_item                   o_head,
    input  wire                              i_pop
);
    import spg_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    t_item             item;
    logic              push;

    always_comb begin
        unique case (i_command)
            3'd0:    item.cmd = CMD_TICK;
            3'd1:    item.cmd = CMD_RUN_RPM;
            3'd2:    item.cmd = CMD_RUN_POWER;
            3'd3:    item.cmd = CMD_MOVE_BY;
            3'd4:    item.cmd = CMD_MOVE_TO;
            3'd5:    item.cmd = CMD_STOP;
            3'd6:    item.cmd = CMD_SET_ZERO;
            default: item.cmd = CMD_NONE;
        endcase
        item.speed = i_speed_q4;
        item.revs  = i_revolutions_q8;
        item.power = i_power_q15;
    end

    assign o_in_stall   = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/spg_div.sv
// ============================================================================
// spg_div - restoring divider
// Unsigned divide, one quotient bit per cycle, done pulses after the last bit.
// ============================================================================
`default_nettype none

module spg_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire  [spg_pkg::DIV_W-1:0]   i_dividend,
    input  wire  [spg_pkg::DVSR_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [spg_pkg::DIV_W-1:0]   o_quot
);
    import spg_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0]   r_quot;
    logic [DVSR_W-1:0]  r_rem;
    logic [DVSR_W-1:0]  r_dvsr;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DVSR_W:0]    rem_sh;
    logic               fits;

    assign rem_sh = {r_rem, r_quot[DIV_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_dvsr});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_W-2:0], fits};
            r_rem  <= fits ? DVSR_W'(rem_sh - {1'b0, r_dvsr}) : DVSR_W'(rem_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> rtl/spg_back.sv
// ============================================================================
// spg_back - motion sequencer
// Runs queued commands against the motion state: ticks in the idle state, speed
// and distance commands through a shared multiplier and divider.
// ============================================================================
`default_nettype none

module spg_back #(
    parameter int TICKS_PER_HALF_SECOND = spg_pkg::TICKS_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  spg_pkg::t_cfg       i_cfg,
    input  wire                 i_head_valid,
    input  spg_pkg::t_item      i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output spg_pkg::t_result    o_result
);
    import spg_pkg::*;

    t_state r_state, n_state;

    // motion state
    logic signed [POS_W-1:0] r_step, n_step, r_target, n_target;
    logic r_running, n_running, r_endless, n_endless;
    logic r_forward, n_forward, r_high, n_high;
    logic [HALF_W-1:0] r_half, n_half, r_tick, n_tick;
    logic n_done;

    // command working registers
    t_cmd                      r_cmd;
    logic signed [SPEED_W-1:0] r_speed;
    logic signed [REV_W-1:0]   r_revs;
    logic signed [POWER_W-1:0] r_power;
    logic r_fwd, n_fwd, r_unb, n_unb, r_pwr, n_pwr;
    t_err r_err, n_err;
    logic [PROD_W-1:0] r_prod;
    logic [SCALE_W-1:0] r_scaled;
    logic [SCALE_W+RECIP_W-1:0] r_recip;
    logic [POS_W-1:0]  r_to_steps;
    logic r_to_fwd, r_to_zero, r_to_fits;
    logic [DVSR_W-1:0] r_to_dm;

    logic              r_out_valid;
    t_result           r_out, result;

    logic out_free, emit, do_halt, do_launch;
    logic [SPEED_W-1:0] h_s_abs, s_abs, sc;
    logic [POWER_W-1:0] h_p_abs, p_abs;
    logic [REV_W-1:0]   r_abs;
    logic h_slow, h_tiny, no_limit, r_slow, to_small;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic mul_en;
    logic div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, div_quot;
    logic [DVSR_W-1:0] div_divisor;
    logic [DIV_W-1:0]  scale_sum, scale_sh;
    logic [SCALE_W+RECIP_W-RECIP_SH-1:0] freq_q;
    logic [DVSR_W-1:0] freq;
    logic [HALF_W-1:0] half_new;
    logic [HALF_W:0]   tick1;
    logic signed [POS_W-1:0] stepped;
    logic [POS_W-1:0] by_steps, zero_mag;
    logic signed [REV_W+MUL_B_W:0] g;
    logic signed [REV_W+MUL_B_W-8:0] q;
    logic [7:0] rem;
    logic signed [POS_W-1:0] e;
    logic [POS_W-1:0] em;

    // ---------------------------------------------------------------- decode
    always_comb begin
        h_s_abs  = i_head.speed[SPEED_W-1] ? SPEED_W'(-i_head.speed) : SPEED_W'(i_head.speed);
        h_p_abs  = i_head.power[POWER_W-1] ? POWER_W'(-i_head.power) : POWER_W'(i_head.power);
        s_abs    = r_speed[SPEED_W-1] ? SPEED_W'(-r_speed) : SPEED_W'(r_speed);
        p_abs    = r_power[POWER_W-1] ? POWER_W'(-r_power) : POWER_W'(r_power);
        r_abs    = r_revs[REV_W-1] ? REV_W'(-r_revs) : REV_W'(r_revs);
        h_slow   = (h_s_abs < SPEED_W'(2));
        h_tiny   = (h_p_abs < POWER_W'(4));
        r_slow   = (s_abs < SPEED_W'(2));
        no_limit = (i_cfg.max_speed == '0);
        sc       = (!no_limit && s_abs > SPEED_W'(i_cfg.max_speed))
                 ? SPEED_W'(i_cfg.max_speed) : s_abs;
        to_small = r_to_fits && (r_prod < PROD_W'({i_cfg.steps_per_rev, 8'h00}));
        out_free = !r_out_valid || !i_out_stall;
        o_pop    = (r_state == ST_IDLE) && i_head_valid
                 && ((i_head.cmd != CMD_TICK) || out_free);
        emit     = ((r_state == ST_IDLE) && i_head_valid && (i_head.cmd == CMD_TICK) && out_free)
                 || ((r_state == ST_FINISH) && out_free);
    end

    // goal distance for move_to, from the registered product |r| * steps_per_rev
    always_comb begin
        g   = r_revs[REV_W-1] ? -$signed({1'b0, r_prod[REV_W+MUL_B_W-1:0]})
                              : $signed({1'b0, r_prod[REV_W+MUL_B_W-1:0]});
        q   = g[REV_W+MUL_B_W:8];
        rem = g[7:0];
        e   = POS_W'(q) - r_step;
        em  = e[POS_W-1] ? POS_W'(-e) : POS_W'(e);
    end

    // ------------------------------------------------------- shared multiply
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (r_state)
            ST_RPM_MUL: begin
                mul_a = MUL_A_W'(sc);
                mul_b = i_cfg.steps_per_rev;
            end
            ST_PWR_MUL1: begin
                mul_a = MUL_A_W'(p_abs);
                mul_b = i_cfg.max_speed;
            end
            ST_PWR_MUL2: begin
                mul_a = MUL_A_W'(r_prod[31:0]);
                mul_b = i_cfg.steps_per_rev;
            end
            ST_DIST_MUL: begin
                mul_a = MUL_A_W'(r_abs);
                mul_b = i_cfg.steps_per_rev;
            end
            ST_TO_MUL: begin
                mul_a = MUL_A_W'(r_to_dm);
                mul_b = NEAR_SCALE;
            end
            default: mul_en = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- divide
    always_comb begin
        // rounded frequency: drop the power-of-two factor, then divide by 15
        scale_sum    = DIV_W'(r_prod) + (r_pwr ? PWR_ROUND : RPM_ROUND);
        scale_sh     = r_pwr ? (scale_sum >> PWR_SHIFT) : (scale_sum >> RPM_SHIFT);
        freq_q       = r_recip[SCALE_W+RECIP_W-1:RECIP_SH];
        freq         = (freq_q == '0) ? DVSR_W'(1) : DVSR_W'(freq_q);
        div_start    = (r_state == ST_DIVH_GO);
        div_dividend = DIV_W'(TICKS_PER_HALF_SECOND);
        div_divisor  = freq;
        if (div_quot == '0) begin
            half_new = HALF_W'(1);
        end else if (div_quot > DIV_W'(HALF_MAX)) begin
            half_new = HALF_MAX;
        end else begin
            half_new = div_quot[HALF_W-1:0];
        end
    end

    spg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    unique case (i_head.cmd)
                        CMD_TICK:      n_state = ST_IDLE;
                        CMD_RUN_RPM:   n_state = (i_head.speed == '0) ? ST_FINISH : ST_RPM_MUL;
                        CMD_RUN_POWER: n_state = (h_tiny || no_limit) ? ST_FINISH : ST_PWR_MUL1;
                        CMD_MOVE_BY: begin
                            if (h_slow) begin
                                n_state = ST_FINISH;
                            end else if (i_head.revs == '0) begin
                                n_state = ST_RPM_MUL;
                            end else begin
                                n_state = ST_DIST_MUL;
                            end
                        end
                        CMD_MOVE_TO:   n_state = ST_DIST_MUL;
                        CMD_SET_ZERO:  n_state = ST_DIST_MUL;
                        CMD_STOP:      n_state = ST_FINISH;
                        CMD_NONE:      n_state = ST_FINISH;
                    endcase
                end
            end
            ST_DIST_MUL: begin
                priority case (r_cmd)
                    CMD_MOVE_BY: n_state = ST_BY_SET;
                    CMD_MOVE_TO: n_state = ST_TO_EVAL;
                    default:     n_state = ST_ZERO_SET;
                endcase
            end
            ST_BY_SET:     n_state = ST_RPM_MUL;
            ST_ZERO_SET:   n_state = ST_FINISH;
            ST_TO_EVAL:    n_state = ST_TO_MUL;
            ST_TO_MUL:     n_state = ST_TO_DEC;
            ST_TO_DEC:     n_state = (to_small || r_slow) ? ST_FINISH : ST_RPM_MUL;
            ST_RPM_MUL:    n_state = ST_FREQ_SCALE;
            ST_PWR_MUL1:   n_state = ST_PWR_MUL2;
            ST_PWR_MUL2:   n_state = ST_FREQ_SCALE;
            ST_FREQ_SCALE: n_state = ST_FREQ_MUL;
            ST_FREQ_MUL:   n_state = ST_DIVH_GO;
            ST_DIVH_GO:    n_state = ST_DIVH_WAIT;
            ST_DIVH_WAIT:  n_state = div_done ? ST_FINISH : ST_DIVH_WAIT;
            ST_FINISH:     n_state = out_free ? ST_IDLE : ST_FINISH;
            default:       n_state = ST_IDLE;
        endcase
    end

    // -------------------------------------------------------- state updates
    always_comb begin
        n_step    = r_step;
        n_target  = r_target;
        n_running = r_running;
        n_endless = r_endless;
        n_forward = r_forward;
        n_high    = r_high;
        n_half    = r_half;
        n_tick    = r_tick;
        n_fwd     = r_fwd;
        n_unb     = r_unb;
        n_pwr     = r_pwr;
        n_err     = r_err;
        n_done    = 1'b0;
        do_halt   = 1'b0;
        do_launch = 1'b0;
        tick1     = {1'b0, r_tick} + 1'b1;
        stepped   = r_forward ? r_step + 1'b1 : r_step - 1'b1;
        by_steps  = POS_W'(r_prod[PROD_W-1:8]);
        zero_mag  = POS_W'(r_prod[PROD_W-1:8]);

        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_err = ERR_OK;
                    n_pwr = 1'b0;
                    unique case (i_head.cmd)
                        CMD_TICK: begin
                            if (r_running) begin
                                if (tick1 >= {1'b0, r_half}) begin
                                    n_tick = '0;
                                    if (r_high) begin
                                        n_high = 1'b0;
                                    end else if (!r_endless
                                            && (r_forward ? (stepped >= r_target)
                                                          : (stepped <= r_target))) begin
                                        n_step    = r_target;
                                        n_running = 1'b0;
                                        n_done    = 1'b1;
                                    end else begin
                                        n_step = stepped;
                                        n_high = 1'b1;
                                    end
                                end else begin
                                    n_tick = tick1[HALF_W-1:0];
                                end
                            end
                        end
                        CMD_RUN_RPM: begin
                            do_halt = (i_head.speed == '0);
                            n_fwd   = !i_head.speed[SPEED_W-1];
                            n_unb   = 1'b1;
                        end
                        CMD_RUN_POWER: begin
                            if (h_tiny) begin
                                do_halt = 1'b1;
                            end else if (no_limit) begin
                                n_err = ERR_NO_LIMIT;
                            end
                            n_fwd = !i_head.power[POWER_W-1];
                            n_unb = 1'b1;
                            n_pwr = 1'b1;
                        end
                        CMD_MOVE_BY: begin
                            if (h_slow) begin
                                do_halt = 1'b1;
                                n_err   = ERR_SLOW_MOVE;
                            end else if (i_head.revs == '0) begin
                                n_fwd = !i_head.speed[SPEED_W-1];
                                n_unb = 1'b1;
                            end else begin
                                n_fwd = (i_head.revs[REV_W-1] == i_head.speed[SPEED_W-1]);
                                n_unb = 1'b0;
                            end
                        end
                        CMD_STOP:     do_halt = 1'b1;
                        CMD_MOVE_TO:  n_unb = 1'b0;
                        CMD_SET_ZERO: n_unb = 1'b0;
                        CMD_NONE:     n_unb = r_unb;
                    endcase
                end
            end
            ST_BY_SET: begin
                n_target = r_fwd ? r_step + by_steps : r_step - by_steps;
            end
            ST_ZERO_SET: begin
                do_halt = 1'b1;
            end
            ST_TO_DEC: begin
                if (!to_small) begin
                    if (r_slow) begin
                        do_halt = 1'b1;
                        n_err   = ERR_SLOW_MOVE;
                    end else if (r_to_zero) begin
                        n_fwd = 1'b1;
                        n_unb = 1'b1;
                    end else begin
                        n_fwd    = r_to_fwd;
                        n_unb    = 1'b0;
                        n_target = r_to_fwd ? r_step + r_to_steps : r_step - r_to_steps;
                    end
                end
            end
            ST_DIVH_WAIT: begin
                do_launch = div_done;
            end
            default: begin
                n_fwd = r_fwd;
            end
        endcase

        if (do_halt) begin
            n_running = 1'b0;
            n_endless = 1'b0;
            n_high    = 1'b0;
            n_tick    = '0;
            n_target  = r_step;
        end
        if (do_launch) begin
            n_forward = r_fwd;
            n_running = 1'b1;
            n_endless = r_unb;
            n_high    = 1'b1;
            n_tick    = '0;
            n_half    = half_new;
        end
        // set_zero places the position at minus the offset in steps
        if (r_state == ST_ZERO_SET) begin
            n_step   = (!r_revs[REV_W-1] && r_revs != '0) ? -$signed(zero_mag)
                                                          : $signed(zero_mag);
            n_target = n_step;
        end
    end

    always_comb begin
        result.step_level = n_running && n_high;
        result.dir_level  = n_forward;
        result.enable_n   = !(i_cfg.enable_present && n_running);
        result.position   = n_step;
        result.moving     = (n_running && n_endless) || (n_step != n_target);
        result.move_done  = n_done;
        result.err        = (r_state == ST_IDLE) ? ERR_OK : r_err;
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_target    <= '0;
            r_running   <= 1'b0;
            r_endless   <= 1'b0;
            r_forward   <= 1'b0;
            r_high      <= 1'b0;
            r_half      <= HALF_W'(1);
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_target  <= n_target;
            r_running <= n_running;
            r_endless <= n_endless;
            r_forward <= n_forward;
            r_high    <= n_high;
            r_half    <= n_half;
            r_tick    <= n_tick;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd <= n_fwd;
        r_unb <= n_unb;
        r_pwr <= n_pwr;
        r_err <= n_err;
        if (o_pop) begin
            r_cmd   <= i_head.cmd;
            r_speed <= i_head.speed;
            r_revs  <= i_head.revs;
            r_power <= i_head.power;
        end
        if (mul_en) begin
            r_prod <= PROD_W'(mul_a * mul_b);
        end
        if (r_state == ST_FREQ_SCALE) begin
            r_scaled <= scale_sh[SCALE_W-1:0];
        end
        if (r_state == ST_FREQ_MUL) begin
            r_recip <= r_scaled * RECIP_15;
        end
        if (r_state == ST_TO_EVAL) begin
            r_to_steps <= (e[POS_W-1] && rem != '0) ? em - 1'b1 : em;
            r_to_fwd   <= (!e[POS_W-1] && e != '0) || (e == '0 && rem != '0);
            r_to_zero  <= (e == '0) && (rem == '0);
            r_to_fits  <= (em[POS_W-1:16] == '0);
            r_to_dm    <= e[POS_W-1] ? {1'b0, em[15:0], 8'h00} - DVSR_W'(rem)
                                     : {1'b0, em[15:0], 8'h00} + DVSR_W'(rem);
        end
        if (emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

>>> rtl/step_dir_pulse_generator.sv
// ============================================================================
// step_dir_pulse_generator - step/direction pulse generator top level
// tick beats: through queue and output register, one per cycle unless stalled
// speed, power and move commands: most pass the 48-bit divider
// that turns the frequency into a half period; one command in the back at a time
// stop, set_zero, errors and unused codes: finish without the divider
// synchronous active-low reset clears motion state, queue and output; resets config
// ============================================================================
`default_nettype none

module step_dir_pulse_generator #(
    parameter int TICKS_PER_HALF_SECOND = spg_pkg::TICKS_DEFAULT
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [2:0]                          i_command,
    input  wire  signed [spg_pkg::SPEED_W-1:0]  i_speed_q4,
    input  wire  signed [spg_pkg::REV_W-1:0]    i_revolutions_q8,
    input  wire  signed [spg_pkg::POWER_W-1:0]  i_power_q15,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic                                o_step_level,
    output logic                                o_dir_level,
    output logic                                o_enable_n_level,
    output logic signed [spg_pkg::POS_W-1:0]    o_position,
    output logic                                o_moving,
    output logic                                o_move_done,
    output logic [1:0]                          o_error_code,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [spg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [spg_pkg::CFG_W-1:0]           i_cfg_data
);
    import spg_pkg::*;

    t_cfg    r_cfg;
    logic    head_valid, pop;
    t_item   head;
    t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_per_rev  <= CFG_W'(200);
            r_cfg.max_speed      <= '0;
            r_cfg.enable_present <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STEPS_PER_REV:  r_cfg.steps_per_rev  <= i_cfg_data;
                CFG_MAX_SPEED:      r_cfg.max_speed      <= i_cfg_data;
                CFG_ENABLE_PRESENT: r_cfg.enable_present <= i_cfg_data[0];
                default:            r_cfg.enable_present <= r_cfg.enable_present;
            endcase
        end
    end

    spg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_speed_q4       (i_speed_q4),
        .i_revolutions_q8 (i_revolutions_q8),
        .i_power_q15      (i_power_q15),
        .o_head_valid     (head_valid),
        .o_head           (head),
        .i_pop            (pop)
    );

    spg_back #(
        .TICKS_PER_HALF_SECOND (TICKS_PER_HALF_SECOND)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (result)
    );

    assign o_step_level     = result.step_level;
    assign o_dir_level      = result.dir_level;
    assign o_enable_n_level = result.enable_n;
    assign o_position       = result.position;
    assign o_moving         = result.moving;
    assign o_move_done      = result.move_done;
    assign o_error_code     = result.err;

endmodule

`default_nettype wire
